FILE: rtl/assert_macros.svh
// assertion macros used by the priority compression mapper
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define PCM_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// same-cycle implication
`define PCM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PCM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/pcm_pkg.sv
// types and codes of the priority compression mapper
package pcm_pkg;

	localparam logic CMD_COUNT  = 1'b0;
	localparam logic CMD_VERTEX = 1'b1;

	typedef struct packed {
		logic       kept;
		logic [7:0] level;
	} map_entry_t;

endpackage

FILE: rtl/pcm_level_map.sv
// priority map store with registered read and write-through bypass
module pcm_level_map #(
	parameter int DEPTH = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [$clog2(DEPTH)-1:0]  wr_addr,
	input  pcm_pkg::map_entry_t       wr_data,
	input  logic                      rd_en,
	input  logic [$clog2(DEPTH)-1:0]  rd_addr,
	output pcm_pkg::map_entry_t       rd_data
);
	import pcm_pkg::*;

	map_entry_t mem [DEPTH];
	map_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// a write in the same cycle as the read, to the same address, is forwarded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_data_q <= '0;
		end else if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/priority_compression_mapper.sv
// priority compression mapper top level
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  cfg      | cfg_valid/cfg_ready  | cfg_data (keep_parity)
//  in       | in_valid/in_stall    | command, level_count, last_level,
//           |                      | vertex_level, vertex_owner
//  out      | out_valid/out_stall  | new_level, kept, merged_count, level_total,
//           |                      | players_swapped, new_owner, final_entry
//
// one item per cycle unless stalled; items pass the input stage, then the result stage
// the map read is issued at acceptance and registered with the item in the input stage
// a count item writes the map as it leaves the input stage, with bypass to a following read
// reset clears stream state and keep_parity; the map needs no clearing pass
// out_stall holds the result register and backs up into in_stall in the same cycle
`include "assert_macros.svh"

module priority_compression_mapper #(
	parameter int MAX_LEVELS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [31:0] level_count,
	input  logic        last_level,
	input  logic [7:0]  vertex_level,
	input  logic        vertex_owner,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  new_level,
	output logic        kept,
	output logic [31:0] merged_count,
	output logic [8:0]  level_total,
	output logic        players_swapped,
	output logic        new_owner,
	output logic        final_entry
);
	import pcm_pkg::*;

	localparam int EW    = $clog2(MAX_LEVELS + 1);
	localparam int CW    = $clog2(MAX_LEVELS);
	localparam int DEPTH = (MAX_LEVELS < 256) ? MAX_LEVELS : 256;
	localparam int AW    = $clog2(DEPTH);

	// configuration
	logic keep_parity_q;

	// stream state
	logic [EW-1:0] entry_index_q;
	logic          first_seen_q;
	logic [CW-1:0] cur_level_q;
	logic          swap_q;
	logic [31:0]   running_total_q;
	logic          stream_done_q;

	// input stage
	logic        valid_s1;
	logic        command_s1;
	logic [31:0] level_count_s1;
	logic        last_level_s1;
	logic [7:0]  vertex_level_s1;
	logic        vertex_owner_s1;

	// result stage
	logic        valid_s2;
	logic [7:0]  new_level_s2;
	logic        kept_s2;
	logic [31:0] merged_count_s2;
	logic [8:0]  level_total_s2;
	logic        players_swapped_s2;
	logic        new_owner_s2;
	logic        final_entry_s2;

	// handshake
	logic in_accept;
	logic fire_s1;

	// next state and result
	logic [EW-1:0] entry_index_n;
	logic          first_seen_n;
	logic [CW-1:0] cur_level_n;
	logic          swap_n;
	logic [31:0]   running_total_n;
	logic          stream_done_n;
	logic [7:0]    res_level;
	logic          res_kept;
	logic [31:0]   res_merged;
	logic [8:0]    res_total;
	logic          res_swapped;
	logic          res_owner;
	logic          res_final;

	// map port
	logic       map_wr_en;
	logic [AW-1:0] map_wr_addr;
	map_entry_t map_wr_data;
	map_entry_t map_rd_data;

	assign fire_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !fire_s1;
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_comb begin
		logic          restart;
		logic [EW-1:0] idx;
		logic          in_range;
		logic [32:0]   sum;
		logic          differ;

		restart         = stream_done_q;
		idx             = restart ? '0 : entry_index_q;
		first_seen_n    = restart ? 1'b0 : first_seen_q;
		cur_level_n     = restart ? '0 : cur_level_q;
		swap_n          = restart ? 1'b0 : swap_q;
		running_total_n = restart ? '0 : running_total_q;
		stream_done_n   = stream_done_q;
		entry_index_n   = entry_index_q;
		in_range        = 32'(idx) < 32'(MAX_LEVELS);
		sum             = 33'(running_total_n) + 33'(level_count_s1);
		differ          = idx[0] ^ cur_level_n[0];
		res_level       = '0;
		res_kept        = 1'b0;
		res_merged      = '0;
		res_total       = '0;
		res_swapped     = 1'b0;
		res_owner       = 1'b0;
		res_final       = 1'b0;
		map_wr_en       = 1'b0;
		map_wr_addr     = idx[AW-1:0];
		map_wr_data     = '0;

		if (command_s1 == CMD_COUNT) begin
			entry_index_n = idx;
			if (in_range) begin
				if (!first_seen_n) begin
					if (keep_parity_q || (level_count_s1 != '0)) begin
						first_seen_n    = 1'b1;
						swap_n          = idx[0];
						cur_level_n     = '0;
						running_total_n = level_count_s1;
						res_kept        = 1'b1;
					end
				end else if (level_count_s1 != '0) begin
					if (differ != swap_n) begin
						cur_level_n     = cur_level_n + CW'(1);
						running_total_n = level_count_s1;
					end else begin
						running_total_n = sum[32] ? '1 : sum[31:0];
					end
					res_kept = 1'b1;
				end
				if (res_kept) begin
					res_level  = 8'(cur_level_n);
					res_merged = running_total_n;
				end
				map_wr_en         = fire_s1 && (32'(idx) < 32'(DEPTH));
				map_wr_data.kept  = res_kept;
				map_wr_data.level = res_kept ? 8'(cur_level_n) : 8'd0;
				entry_index_n     = idx + EW'(1);
			end
			stream_done_n = last_level_s1;
			res_final     = last_level_s1;
			if (last_level_s1) begin
				res_total   = first_seen_n ? (9'(cur_level_n) + 9'd1) : 9'd0;
				res_swapped = swap_n;
			end
		end else begin
			// vertex items leave the stream state untouched
			first_seen_n    = first_seen_q;
			cur_level_n     = cur_level_q;
			swap_n          = swap_q;
			running_total_n = running_total_q;
			res_swapped     = swap_q;
			res_owner       = vertex_owner_s1 ^ swap_q;
			if ((32'(vertex_level_s1) < 32'(entry_index_q)) && map_rd_data.kept) begin
				res_level = map_rd_data.level;
				res_kept  = 1'b1;
			end
		end
	end

	pcm_level_map #(
		.DEPTH(DEPTH)
	) u_level_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (map_wr_en),
		.wr_addr (map_wr_addr),
		.wr_data (map_wr_data),
		.rd_en   (in_accept),
		.rd_addr (vertex_level[AW-1:0]),
		.rd_data (map_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_parity_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			keep_parity_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_index_q   <= '0;
			first_seen_q    <= 1'b0;
			cur_level_q     <= '0;
			swap_q          <= 1'b0;
			running_total_q <= '0;
			stream_done_q   <= 1'b0;
		end else if (fire_s1) begin
			entry_index_q   <= entry_index_n;
			first_seen_q    <= first_seen_n;
			cur_level_q     <= cur_level_n;
			swap_q          <= swap_n;
			running_total_q <= running_total_n;
			stream_done_q   <= stream_done_n;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			command_s1      <= command;
			level_count_s1  <= level_count;
			last_level_s1   <= last_level;
			vertex_level_s1 <= vertex_level;
			vertex_owner_s1 <= vertex_owner;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || !out_stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			new_level_s2       <= res_level;
			kept_s2            <= res_kept;
			merged_count_s2    <= res_merged;
			level_total_s2     <= res_total;
			players_swapped_s2 <= res_swapped;
			new_owner_s2       <= res_owner;
			final_entry_s2     <= res_final;
		end
	end

	assign out_valid       = valid_s2;
	assign new_level       = new_level_s2;
	assign kept            = kept_s2;
	assign merged_count    = merged_count_s2;
	assign level_total     = level_total_s2;
	assign players_swapped = players_swapped_s2;
	assign new_owner       = new_owner_s2;
	assign final_entry     = final_entry_s2;

	`PCM_ASSERT_IMP(a_stall_only_when_full, in_stall, valid_s1 && valid_s2 && out_stall,
		"input stalled without a blocked item ahead")
	`PCM_ASSERT(a_index_bounded, 32'(entry_index_q) <= 32'(MAX_LEVELS),
		"entry index beyond the level limit")
	`PCM_ASSERT_IMP(a_level_below_index, first_seen_q,
		32'(cur_level_q) < 32'(entry_index_q), "new level not below the entry count")
	`PCM_ASSERT_IMP(a_removed_has_no_count, valid_s2 && !kept_s2,
		(merged_count_s2 == '0) && (new_level_s2 == '0), "removed item carries a level or count")
	`PCM_ASSERT_NXT(a_stall_holds_result, valid_s2 && out_stall, valid_s2 && $stable(kept_s2),
		"held result changed")

endmodule
